// ===== rtl/clcd_pkg.sv =====
// ----------------------------------------------------------------------------
// clcd_pkg
// types, constants and helpers shared by the character lcd write sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

  localparam int CMD_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int LINE_W    = 2;
  localparam int COLUMN_W  = 5;
  localparam int PCT_W     = 7;
  localparam int HOLD_W    = 13;
  localparam int DAC_W     = 11;
  localparam int PULSE_W   = 8;
  localparam int EXEC_W    = 10;
  localparam int CLEAR_W   = 12;
  localparam int STEP_W    = 4;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [PULSE_W-1:0] PULSE_RESET = 8'd2;
  localparam logic [EXEC_W-1:0]  EXEC_RESET  = 10'd80;
  localparam logic [CLEAR_W-1:0] CLEAR_RESET = 12'd3000;

  localparam logic [BYTE_W-1:0] LCD_CLEAR      = 8'h01;
  localparam logic [BYTE_W-1:0] LCD_CURSOR_ON  = 8'h0E;
  localparam logic [BYTE_W-1:0] LCD_CURSOR_OFF = 8'h0C;
  localparam logic [BYTE_W-1:0] LCD_SET_ADDR   = 8'h80;

  // floor(x / 100) for x up to 186100 as (x * 167773) >> 24, folded with 1861
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam int               DAC_SHIFT = 24;
  localparam logic [28:0]      DAC_SCALE = 29'd312225553;

  localparam logic [HOLD_W-1:0] RS_SETTLE = 13'd1;

  typedef enum logic [CMD_W-1:0] {
    KIND_CMD      = 2'd0,
    KIND_DATA     = 2'd1,
    KIND_CURSOR   = 2'd2,
    KIND_CONTRAST = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_ENABLE_PULSE = 2'd0,
    REG_EXEC_WAIT    = 2'd1,
    REG_CLEAR_WAIT   = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [DAC_W-1:0]  dac;
  } entry_t;

  typedef struct packed {
    logic [PULSE_W-1:0] enable_pulse;
    logic [EXEC_W-1:0]  exec_wait;
    logic [CLEAR_W-1:0] clear_wait;
  } cfg_t;

  function automatic logic [BYTE_W-1:0] row_base(input logic [LINE_W-1:0] line);
    logic [BYTE_W-1:0] base;
    case (line)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      default: base = 8'h54;
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/clcd_if.sv =====
// ----------------------------------------------------------------------------
// clcd request and result channels
// valid/ready channels carrying lcd requests in and pin states out
// ----------------------------------------------------------------------------
`default_nettype none

interface clcd_in_if;
  import clcd_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [BYTE_W-1:0]   value;
  logic [LINE_W-1:0]   line;
  logic [COLUMN_W-1:0] column;
  logic                cursor_on;
  logic [PCT_W-1:0]    contrast_percent;

  modport source (output valid, cmd, value, line, column, cursor_on, contrast_percent,
                  input ready);
  modport sink   (input valid, cmd, value, line, column, cursor_on, contrast_percent,
                  output ready);
endinterface

interface clcd_out_if;
  import clcd_pkg::*;

  logic              valid;
  logic              ready;
  logic              rs_pin;
  logic              en_pin;
  logic [BYTE_W-1:0] data_pins;
  logic [HOLD_W-1:0] hold_us;
  logic [DAC_W-1:0]  dac_code;
  logic              is_last;

  modport source (output valid, rs_pin, en_pin, data_pins, hold_us, dac_code, is_last,
                  input ready);
  modport sink   (input valid, rs_pin, en_pin, data_pins, hold_us, dac_code, is_last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/char_lcd_write_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer
// turns lcd requests into timed pin states for an 8-bit parallel lcd bus
// ----------------------------------------------------------------------------
// first result is shown once the request has passed the front entry register, the queue and the result register
// results leave one per cycle while the output is not stalled: 4 for a command, 2 for data, 9 for set cursor,
// 1 for contrast; a new request is taken every cycle while the queue has room
// the pin-state stepper in the back part sets the rate, one result per cycle while the output is not stalled
// synchronous active-low reset clears the queue and restores register
// defaults, rs high and data lines low; no clearing pass
`default_nettype none

module char_lcd_write_sequencer #(
  parameter int QUEUE_DEPTH = clcd_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  clcd_in_if.sink                            in_req,
  clcd_out_if.source                         out_res,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [clcd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [clcd_pkg::PDATA_W-1:0]  pwdata,
  output logic      [clcd_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);
  import clcd_pkg::*;

  logic [PULSE_W-1:0] enable_pulse_r;
  logic [EXEC_W-1:0]  exec_wait_r;
  logic [CLEAR_W-1:0] clear_wait_r;
  cfg_t               cfg;
  reg_idx_t           reg_idx;
  logic               wr_en;

  logic   push_valid, push_ready, q_valid, q_ready;
  entry_t push_data, q_data;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_pulse_r <= PULSE_RESET;
      exec_wait_r    <= EXEC_RESET;
      clear_wait_r   <= CLEAR_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ENABLE_PULSE: enable_pulse_r <= pwdata[PULSE_W-1:0];
        REG_EXEC_WAIT:    exec_wait_r    <= pwdata[EXEC_W-1:0];
        REG_CLEAR_WAIT:   clear_wait_r   <= pwdata[CLEAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENABLE_PULSE: prdata = {{(PDATA_W-PULSE_W){1'b0}}, enable_pulse_r};
      REG_EXEC_WAIT:    prdata = {{(PDATA_W-EXEC_W){1'b0}}, exec_wait_r};
      REG_CLEAR_WAIT:   prdata = {{(PDATA_W-CLEAR_W){1'b0}}, clear_wait_r};
      default:          prdata = '0;
    endcase
  end

  assign cfg.enable_pulse = enable_pulse_r;
  assign cfg.exec_wait    = exec_wait_r;
  assign cfg.clear_wait   = clear_wait_r;

  clcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  clcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  clcd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .out_res (out_res)
  );

endmodule

`default_nettype wire

// ===== rtl/clcd_front.sv =====
// ----------------------------------------------------------------------------
// clcd_front
// takes requests, works out cursor address bytes and contrast code, registers
// one decoded entry for the queue
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  clcd_in_if.sink              in_req,
  output logic                 push_valid,
  input  wire logic            push_ready,
  output clcd_pkg::entry_t     push_data
);
  import clcd_pkg::*;

  logic   fv_r, fv_nxt;
  entry_t entry_r;
  entry_t entry_nxt;

  logic [BYTE_W-1:0] addr;
  logic [PCT_W-1:0]  pct_diff;
  logic [35:0]       dac_prod;
  logic              take;

  assign in_req.ready = !fv_r || push_ready;
  assign take         = in_req.valid && in_req.ready;
  assign push_valid   = fv_r;
  assign push_data    = entry_r;

  always_comb begin
    addr      = (row_base(in_req.line) + {3'b000, in_req.column}) | LCD_SET_ADDR;
    pct_diff  = PCT_FULL - in_req.contrast_percent;
    dac_prod  = {29'd0, pct_diff} * {7'd0, DAC_SCALE};

    entry_nxt.kind  = kind_t'(in_req.cmd);
    entry_nxt.byte0 = in_req.value;
    entry_nxt.byte1 = in_req.value;
    entry_nxt.dac   = '0;
    case (kind_t'(in_req.cmd))
      KIND_CURSOR: begin
        entry_nxt.byte0 = in_req.cursor_on ? addr : LCD_CURSOR_OFF;
        entry_nxt.byte1 = in_req.cursor_on ? LCD_CURSOR_ON : addr;
      end
      KIND_CONTRAST: begin
        if (in_req.contrast_percent < PCT_FULL) begin
          entry_nxt.dac = dac_prod[DAC_SHIFT+DAC_W-1:DAC_SHIFT];
        end
      end
      default: begin
      end
    endcase

    fv_nxt = take ? 1'b1 : (push_ready ? 1'b0 : fv_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      entry_r <= entry_nxt;
    end
  end

  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fv_r && !push_ready |=> fv_r && $stable(entry_r))
    else $error("front entry changed while the queue was full");

endmodule

`default_nettype wire

// ===== rtl/clcd_queue.sv =====
// ----------------------------------------------------------------------------
// clcd_queue
// short queue of decoded requests between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_queue #(
  parameter int DEPTH = clcd_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire clcd_pkg::entry_t  push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output clcd_pkg::entry_t       pop_data
);
  import clcd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic push, pop;

  assign push_ready = count_r != FULL_CNT;
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count lost a request");

endmodule

`default_nettype wire

// ===== rtl/clcd_back.sv =====
// ----------------------------------------------------------------------------
// clcd_back
// steps through the pin states of the request at the queue head into the
// result register, one per cycle while the output is not stalled
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire clcd_pkg::cfg_t    cfg,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire clcd_pkg::entry_t  q_data,
  clcd_out_if.source             out_res
);
  import clcd_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              rs_level_r, rs_level_nxt;
  logic [BYTE_W-1:0] data_level_r, data_level_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              rs_r, en_r, last_r;
  logic [BYTE_W-1:0] data_r;
  logic [HOLD_W-1:0] hold_r;
  logic [DAC_W-1:0]  dac_r;

  logic              rs_c, en_c, last_c;
  logic [BYTE_W-1:0] data_c, byte_sel;
  logic [HOLD_W-1:0] hold_c;
  logic [DAC_W-1:0]  dac_c;
  logic [STEP_W-1:0] last_step;
  logic [1:0]        sub;
  logic              tail, advance;

  assign advance = q_valid && (!out_valid_r || out_res.ready);

  always_comb begin
    last_step = '0;
    sub       = step_r[1:0];
    byte_sel  = q_data.byte0;
    tail      = 1'b0;
    case (q_data.kind)
      KIND_CMD: begin
        last_step = 4'd3;
      end
      KIND_DATA: begin
        last_step = 4'd1;
        sub       = step_r[1:0] + 2'd1;
      end
      KIND_CURSOR: begin
        last_step = 4'd8;
        byte_sel  = step_r[2] ? q_data.byte1 : q_data.byte0;
        tail      = step_r[3];
      end
      KIND_CONTRAST: begin
        tail      = 1'b1;
      end
      default: begin
      end
    endcase
    last_c = step_r == last_step;

    rs_c   = rs_level_r;
    en_c   = 1'b0;
    data_c = byte_sel;
    hold_c = '0;
    dac_c  = '0;
    if (tail) begin
      if (q_data.kind == KIND_CONTRAST) begin
        data_c = data_level_r;
        dac_c  = q_data.dac;
      end else begin
        data_c = '0;
      end
    end else begin
      case (sub)
        2'd0: begin
          rs_c   = 1'b0;
          data_c = data_level_r;
          hold_c = RS_SETTLE;
        end
        2'd1: begin
          en_c   = 1'b1;
          hold_c = HOLD_W'(cfg.enable_pulse);
        end
        2'd2: begin
          hold_c = HOLD_W'(cfg.exec_wait);
        end
        default: begin
          rs_c   = 1'b1;
          hold_c = RS_SETTLE;
          if (byte_sel == LCD_CLEAR) begin
            hold_c = RS_SETTLE + HOLD_W'(cfg.clear_wait);
          end
        end
      endcase
    end

    step_nxt       = step_r;
    rs_level_nxt   = rs_level_r;
    data_level_nxt = data_level_r;
    out_valid_nxt  = out_res.ready ? 1'b0 : out_valid_r;
    if (advance) begin
      step_nxt       = last_c ? '0 : step_r + 1'b1;
      rs_level_nxt   = rs_c;
      data_level_nxt = data_c;
      out_valid_nxt  = 1'b1;
    end
  end

  assign q_ready = advance && last_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= '0;
      rs_level_r   <= 1'b1;
      data_level_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      step_r       <= step_nxt;
      rs_level_r   <= rs_level_nxt;
      data_level_r <= data_level_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rs_r   <= rs_c;
      en_r   <= en_c;
      data_r <= data_c;
      hold_r <= hold_c;
      dac_r  <= dac_c;
      last_r <= last_c;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.rs_pin    = rs_r;
  assign out_res.en_pin    = en_r;
  assign out_res.data_pins = data_r;
  assign out_res.hold_us   = hold_r;
  assign out_res.dac_code  = dac_r;
  assign out_res.is_last   = last_r;

  a_step_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != '0 |-> q_valid)
    else $error("sequencer mid request with an empty queue");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> step_r <= last_step)
    else $error("sequencer step beyond the request length");

  a_rs_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == '0 |-> rs_level_r)
    else $error("rs left low between requests");

endmodule

`default_nettype wire
